/* sv/asgm_pkg.sv */
// shared types and constants for the activity segment gap merger
package asgm_pkg;

	// fixed field widths
	localparam int FW        = 20;
	localparam int CH_W      = 3;
	localparam int CFG_W     = 20;
	localparam int CFG_IDX_W = 1;

	// stream word widths, rounded up to whole bytes
	localparam int S_TDATA_W = 24;
	localparam int M_TDATA_W = 48;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_MERGE_GAP  = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_MIN_LENGTH = 1'b1;

	// reset value of both registers
	localparam logic [CFG_W-1:0] CFG_RESET = 20'd30;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_CALC,
		ST_WRD,
		ST_WOUT
	} asgm_state_t;

endpackage

/* sv/asgm_ram.sv */
// generic simple dual-port ram with registered read
module asgm_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                                  clk,
	input  logic                                  we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                      wdata,
	input  logic                                  re,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                      rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

/* sv/activity_segment_gap_merger_core.sv */
// top level of the activity segment gap merger
// an item that emits nothing is accepted with a channel state read, then updated
// a finalized group of n kept segments adds one segment store read per result
// first result word is registered after the calc and store read states; the store port sets the pace
// reset clears the control state, the registers (30 each) and every channel's valid bit,
// so every channel reads as idle; the segment store is not cleared and needs no clearing pass
module activity_segment_gap_merger_core #(
	parameter int CHANNELS = 8,
	parameter int MAX_SEGS = 16
) (
	input  logic                           clk,
	input  logic                           arst_n,
	// input words
	input  logic                           s_tvalid,
	output logic                           s_tready,
	input  logic [asgm_pkg::S_TDATA_W-1:0] s_tdata,  // channel[2:0], selected[3], frame_index[23:4]
	input  logic                           s_tuser,  // flush
	// result words
	output logic                           m_tvalid,
	input  logic                           m_tready,
	output logic [asgm_pkg::M_TDATA_W-1:0] m_tdata,  // out_channel[2:0], seg_start[22:3], seg_end[42:23]
	output logic                           m_tlast,  // last_of_group
	output logic                           m_tuser,  // overflow
	// register writes
	input  logic                           cfg_we,
	input  logic [asgm_pkg::CFG_IDX_W-1:0] cfg_idx,
	input  logic [asgm_pkg::CFG_W-1:0]     cfg_wdata
);

	import asgm_pkg::*;

	localparam int CH_AW    = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
	localparam int CNT_W    = $clog2(MAX_SEGS + 1);
	localparam int K_W      = (MAX_SEGS > 1) ? $clog2(MAX_SEGS) : 1;
	localparam int ST_DEPTH = CHANNELS * MAX_SEGS;
	localparam int ST_AW    = (ST_DEPTH > 1) ? $clog2(ST_DEPTH) : 1;
	localparam int ST_W     = 2 * FW;
	localparam int PAD_W    = M_TDATA_W - CH_W - 2 * FW;

	// per channel bookkeeping, one word of the channel state ram
	typedef struct packed {
		logic             seg_open;
		logic             grp_active;
		logic [FW-1:0]    grp_start;
		logic [FW-1:0]    grp_end;
		logic [FW-1:0]    last_start;  // start of the last stored segment
		logic [CNT_W-1:0] grp_count;
		logic             grp_ovf;
	} chan_state_t;

	localparam int CS_W = $bits(chan_state_t);

	// store entry address: channel row plus segment slot
	function automatic logic [ST_AW-1:0] st_addr(logic [CH_AW-1:0] c, logic [K_W-1:0] k);
		return ST_AW'(c) * ST_AW'(MAX_SEGS) + ST_AW'(k);
	endfunction

	// group span check at finalization
	function automatic logic fin_ok(chan_state_t s, logic [FW-1:0] ml);
		return s.grp_active && (s.grp_count != '0) && (s.grp_end >= s.grp_start)
			&& ((s.grp_end - s.grp_start) >= ml);
	endfunction

	asgm_state_t state_q, state_d;

	// registers
	logic [CFG_W-1:0] merge_gap_q, min_length_q;

	// accepted word
	logic [CH_W-1:0] ch_q;
	logic            sel_q;
	logic [FW-1:0]   frame_q;
	logic            flush_q;
	logic [CH_AW-1:0] ch_idx;
	logic            in_range;

	// channel state valid bits, cleared by reset
	logic [CHANNELS-1:0] valid_q;

	// channel state ram
	logic              cs_we, cs_re;
	logic [CH_AW-1:0]  cs_raddr;
	logic [CS_W-1:0]   cs_rdata;
	chan_state_t       cur, nxt;

	// segment store ram
	logic              st_we, st_re;
	logic [ST_AW-1:0]  st_waddr, st_raddr;
	logic [ST_W-1:0]   st_wdata, st_rdata;

	// update decisions made in the calc cycle
	logic              emit;
	logic              cw_en, cw_open;
	logic [ST_AW-1:0]  cw_addr;
	logic [ST_W-1:0]   cw_data;
	logic              grp_join;

	// new segment write held back until the old group has been read out
	logic              dw_q;
	logic [ST_AW-1:0]  dw_addr_q;
	logic [ST_W-1:0]   dw_data_q;

	// walk over the finalized group
	logic [CNT_W-1:0]  k_q, wcnt_q;
	logic              wovf_q;
	logic              walk_last;
	logic              load_out;

	// output register
	logic              m_tvalid_q;
	logic [CH_W-1:0]   out_ch_q;
	logic [FW-1:0]     out_start_q, out_end_q;
	logic              out_last_q, out_ovf_q;

	assign ch_idx   = CH_AW'(ch_q);
	assign in_range = (32'(ch_q) < CHANNELS);
	assign cs_raddr = CH_AW'(s_tdata[CH_W-1:0]);

	asgm_ram #(.WIDTH(CS_W), .DEPTH(CHANNELS)) u_cs_ram (
		.clk   (clk),
		.we    (cs_we),
		.waddr (ch_idx),
		.wdata (nxt),
		.re    (cs_re),
		.raddr (cs_raddr),
		.rdata (cs_rdata)
	);

	asgm_ram #(.WIDTH(ST_W), .DEPTH(ST_DEPTH)) u_st_ram (
		.clk   (clk),
		.we    (st_we),
		.waddr (st_waddr),
		.wdata (st_wdata),
		.re    (st_re),
		.raddr (st_raddr),
		.rdata (st_rdata)
	);

	// read-modify of the channel state, valid only in the calc cycle
	always_comb begin
		cur      = valid_q[ch_idx] ? chan_state_t'(cs_rdata) : '0;
		nxt      = cur;
		emit     = 1'b0;
		cw_en    = 1'b0;
		cw_open  = 1'b0;
		cw_addr  = '0;
		cw_data  = '0;
		grp_join = cur.grp_active
			&& ((frame_q < cur.grp_end) || ((frame_q - cur.grp_end) < merge_gap_q));

		// close the open segment: end goes into the last stored entry
		if ((flush_q || !sel_q) && cur.seg_open) begin
			nxt.seg_open = 1'b0;
			if (cur.grp_active && (cur.grp_count != '0)) begin
				cw_en       = 1'b1;
				cw_addr     = st_addr(ch_idx, K_W'(CNT_W'(cur.grp_count - CNT_W'(1))));
				cw_data     = {frame_q, cur.last_start};
				nxt.grp_end = frame_q;
			end
		end

		if (flush_q) begin
			// finalize after the close
			emit           = fin_ok(nxt, min_length_q);
			nxt.grp_active = 1'b0;
			nxt.grp_count  = '0;
			nxt.grp_ovf    = 1'b0;
		end else if (sel_q && !cur.seg_open) begin
			// rising select: too far from the group end starts a new group
			if (!grp_join) begin
				emit           = fin_ok(cur, min_length_q);
				nxt.grp_active = 1'b1;
				nxt.grp_start  = frame_q;
				nxt.grp_end    = frame_q;
				nxt.grp_count  = '0;
				nxt.grp_ovf    = 1'b0;
			end
			if (nxt.grp_count < CNT_W'(MAX_SEGS)) begin
				cw_en          = 1'b1;
				cw_open        = 1'b1;
				cw_addr        = st_addr(ch_idx, K_W'(nxt.grp_count));
				cw_data        = {{FW{1'b0}}, frame_q};
				nxt.last_start = frame_q;
				nxt.grp_count  = CNT_W'(nxt.grp_count + CNT_W'(1));
			end else begin
				// store full: later closes stretch the last entry
				nxt.grp_ovf = 1'b1;
			end
			nxt.seg_open = 1'b1;
		end
	end

	assign walk_last = (CNT_W'(k_q + CNT_W'(1)) == wcnt_q);

	// sequencer
	always_comb begin
		state_d  = state_q;
		s_tready = 1'b0;
		cs_re    = 1'b0;
		cs_we    = 1'b0;
		st_re    = 1'b0;
		st_we    = 1'b0;
		st_waddr = cw_addr;
		st_wdata = cw_data;
		st_raddr = st_addr(ch_idx, k_q[K_W-1:0]);
		load_out = 1'b0;
		case (state_q)
			ST_IDLE: begin
				s_tready = 1'b1;
				cs_re    = s_tvalid;
				if (s_tvalid) begin
					state_d = ST_CALC;
				end
			end
			ST_CALC: begin
				if (in_range) begin
					cs_we = 1'b1;
					// a close write lands before the walk reads it back
					st_we = cw_en && !(cw_open && emit);
					state_d = emit ? ST_WRD : ST_IDLE;
				end else begin
					state_d = ST_IDLE;
				end
			end
			ST_WRD: begin
				st_re   = 1'b1;
				state_d = ST_WOUT;
			end
			ST_WOUT: begin
				if (!m_tvalid_q || m_tready) begin
					load_out = 1'b1;
					if (walk_last) begin
						// old group is out, entry 0 may now take the new segment
						st_we    = dw_q;
						st_waddr = dw_addr_q;
						st_wdata = dw_data_q;
						state_d  = ST_IDLE;
					end else begin
						state_d = ST_WRD;
					end
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			valid_q      <= '0;
			merge_gap_q  <= CFG_RESET;
			min_length_q <= CFG_RESET;
			m_tvalid_q   <= 1'b0;
			dw_q         <= 1'b0;
			k_q          <= '0;
		end else begin
			state_q <= state_d;
			if (cfg_we) begin
				case (cfg_idx)
					CFG_MERGE_GAP:  merge_gap_q  <= cfg_wdata;
					CFG_MIN_LENGTH: min_length_q <= cfg_wdata;
					default: ;
				endcase
			end
			if (cs_we) begin
				valid_q[ch_idx] <= 1'b1;
			end
			if (load_out) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
			if (state_q == ST_CALC) begin
				dw_q <= cw_en && cw_open && emit;
				k_q  <= '0;
			end else if (load_out) begin
				k_q <= CNT_W'(k_q + CNT_W'(1));
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			ch_q    <= s_tdata[CH_W-1:0];
			sel_q   <= s_tdata[CH_W];
			frame_q <= s_tdata[CH_W+FW:CH_W+1];
			flush_q <= s_tuser;
		end
		if (state_q == ST_CALC) begin
			wcnt_q    <= cur.grp_count;
			wovf_q    <= cur.grp_ovf;
			dw_addr_q <= cw_addr;
			dw_data_q <= cw_data;
		end
		if (load_out) begin
			out_ch_q    <= ch_q;
			out_start_q <= st_rdata[FW-1:0];
			out_end_q   <= st_rdata[ST_W-1:FW];
			out_last_q  <= walk_last;
			out_ovf_q   <= wovf_q;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {{PAD_W{1'b0}}, out_end_q, out_start_q, out_ch_q};
	assign m_tlast  = out_last_q;
	assign m_tuser  = out_ovf_q;

endmodule

/* sv/asgm_checker.sv */
// port-level checks for the activity segment gap merger, bound to the top level
module asgm_checker #(
	parameter int CHANNELS = 8
) (
	input logic                           clk,
	input logic                           arst_n,
	input logic                           s_tvalid,
	input logic                           s_tready,
	input logic                           m_tvalid,
	input logic                           m_tready,
	input logic [asgm_pkg::M_TDATA_W-1:0] m_tdata,
	input logic                           m_tlast,
	input logic                           m_tuser
);

	import asgm_pkg::*;

	// an accepted word is worked on before the next is taken
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("input taken in the cycle after an accept");

	// a result word is only produced while the input side is held off
	a_result_from_walk: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> $past(!s_tready))
		else $error("result word appeared while idle");

	// stalled result word holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast)
			&& $stable(m_tuser))
		else $error("stalled result word changed");

	// results only name channels that exist
	a_out_channel: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (32'(m_tdata[CH_W-1:0]) < CHANNELS))
		else $error("result word for a channel out of range");

endmodule

bind activity_segment_gap_merger_core asgm_checker #(.CHANNELS(CHANNELS)) u_asgm_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tlast  (m_tlast),
	.m_tuser  (m_tuser)
);
